>>> design/rtu_request_frame_checker_unit_defines.svh
// Assertion macros for the request frame checker.
`ifndef RTU_REQUEST_FRAME_CHECKER_UNIT_DEFINES_SVH
`define RTU_REQUEST_FRAME_CHECKER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Checked on every clock edge outside reset.
`define RTU_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("rtu frame checker: assertion failed");
// Checked on every clock edge, reset included.
`define RTU_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("rtu frame checker: assertion failed");
`else
`define RTU_ASSERT(lbl, prop)
`define RTU_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

>>> design/rtu_frm_pkg.sv
package rtu_frm_pkg;

  localparam int FRAME_BYTES = 8;
  localparam int CNT_W = $clog2(FRAME_BYTES);

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0] EXCEPTION_LIMIT = 8'h80;
  localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;

  // Byte positions within a frame.
  localparam logic [CNT_W-1:0] POS_STATION = CNT_W'(0);
  localparam logic [CNT_W-1:0] POS_FUNCTION = CNT_W'(1);
  localparam logic [CNT_W-1:0] POS_REG_HI = CNT_W'(2);
  localparam logic [CNT_W-1:0] POS_REG_LO = CNT_W'(3);
  localparam logic [CNT_W-1:0] POS_QTY_HI = CNT_W'(4);
  localparam logic [CNT_W-1:0] POS_QTY_LO = CNT_W'(5);
  localparam logic [CNT_W-1:0] POS_CRC_LO = CNT_W'(FRAME_BYTES - 2);
  localparam logic [CNT_W-1:0] POS_LAST = CNT_W'(FRAME_BYTES - 1);
  // Advance of the byte position per accepted item.
  localparam logic [CNT_W-1:0] POS_STEP = CNT_W'(1);

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_CRC  = 2'd1,
    ST_ADDR = 2'd2,
    ST_EXC  = 2'd3
  } status_t;

  typedef struct packed {
    status_t     status;
    logic [7:0]  station;
    logic [7:0]  func_code;
    logic [15:0] register_address;
    logic [15:0] quantity;
    logic [15:0] frame_crc;
  } result_t;

  // Reflected CRC-16 over one byte, eight shift steps.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

>>> design/rtu_request_frame_checker_unit.sv
// Checks fixed eight-byte RTU request frames arriving one byte per item. The
// block sustains one byte per clock unless input is stalled; the eight-step
// CRC update is unrolled between the frame state registers. A frame's result
// appears on the output register in the cycle after its last byte is accepted.
// Input is stalled only when a last byte arrives while the previous result is
// still waiting to be taken. A byte flagged with frame_start restarts the
// frame and drops any partial one without a result.
`include "rtu_request_frame_checker_unit_defines.svh"

module rtu_request_frame_checker_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  slave_address,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  frame_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  status,
  output logic [7:0]  station,
  output logic [7:0]  func_code,
  output logic [15:0] register_address,
  output logic [15:0] quantity,
  output logic [15:0] frame_crc
);

  logic [7:0] slave_addr_reg;
  logic accept;
  logic last_byte;
  logic fire;
  rtu_frm_pkg::result_t result;
  rtu_frm_pkg::result_t held;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      slave_addr_reg <= rtu_frm_pkg::SLAVE_ADDRESS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      slave_addr_reg <= slave_address;
    end
  end

  assign in_stall = last_byte && out_valid && out_stall;
  assign accept = in_valid && !in_stall;

  rtu_frm_track u_track (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .frame_byte    (frame_byte),
    .frame_start   (frame_start),
    .slave_address (slave_addr_reg),
    .last_byte     (last_byte),
    .fire          (fire),
    .result        (result)
  );

  rtu_frm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .held      (held)
  );

  assign status = held.status;
  assign station = held.station;
  assign func_code = held.func_code;
  assign register_address = held.register_address;
  assign quantity = held.quantity;
  assign frame_crc = held.frame_crc;

  `RTU_ASSERT(a_fire_shows_result, fire |=> out_valid)
  `RTU_ASSERT(a_ok_addr, out_valid && status == rtu_frm_pkg::ST_OK |-> station == slave_addr_reg)
  `RTU_ASSERT(a_ok_function, out_valid && status == rtu_frm_pkg::ST_OK |-> !func_code[7])
  `RTU_ASSERT_ALWAYS(a_reset_clears_output, rst |=> !out_valid)

endmodule

>>> design/rtu_frm_track.sv
module rtu_frm_track (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     accept,
  input  logic [7:0]               frame_byte,
  input  logic                     frame_start,
  input  logic [7:0]               slave_address,
  output logic                     last_byte,
  output logic                     fire,
  output rtu_frm_pkg::result_t     result
);

  logic [rtu_frm_pkg::CNT_W-1:0] byte_count;
  logic [rtu_frm_pkg::CNT_W-1:0] byte_count_next;
  logic [15:0] running_crc;
  logic [15:0] running_crc_next;
  logic [7:0]  held_station;
  logic [7:0]  held_function;
  logic [15:0] held_register;
  logic [15:0] held_quantity;
  logic [7:0]  held_crc_low;

  logic [rtu_frm_pkg::CNT_W-1:0] pos;
  logic [15:0] crc_base;
  logic [15:0] rx_crc;

  assign pos = frame_start ? rtu_frm_pkg::POS_STATION : byte_count;
  assign crc_base = frame_start ? rtu_frm_pkg::CRC_INIT : running_crc;
  assign last_byte = (pos == rtu_frm_pkg::POS_LAST);
  assign fire = accept && last_byte;
  assign rx_crc = {frame_byte, held_crc_low};

  always_comb begin
    if (last_byte) begin
      byte_count_next = rtu_frm_pkg::POS_STATION;
      running_crc_next = rtu_frm_pkg::CRC_INIT;
    end else begin
      byte_count_next = pos + rtu_frm_pkg::POS_STEP;
      if (pos < rtu_frm_pkg::POS_CRC_LO) begin
        running_crc_next = rtu_frm_pkg::crc_byte(crc_base, frame_byte);
      end else begin
        running_crc_next = crc_base;
      end
    end
  end

  // The CRC at the last byte already covers bytes 0..5, so it is compared as held.
  always_comb begin
    result.station = held_station;
    result.func_code = held_function;
    result.register_address = held_register;
    result.quantity = held_quantity;
    result.frame_crc = rx_crc;
    if (rx_crc != running_crc) begin
      result.status = rtu_frm_pkg::ST_CRC;
    end else if (held_station != slave_address) begin
      result.status = rtu_frm_pkg::ST_ADDR;
    end else if (held_function >= rtu_frm_pkg::EXCEPTION_LIMIT) begin
      result.status = rtu_frm_pkg::ST_EXC;
    end else begin
      result.status = rtu_frm_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= rtu_frm_pkg::POS_STATION;
      running_crc <= rtu_frm_pkg::CRC_INIT;
    end else if (accept) begin
      byte_count <= byte_count_next;
      running_crc <= running_crc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      case (pos)
        rtu_frm_pkg::POS_STATION:  held_station <= frame_byte;
        rtu_frm_pkg::POS_FUNCTION: held_function <= frame_byte;
        rtu_frm_pkg::POS_REG_HI:   held_register[15:8] <= frame_byte;
        rtu_frm_pkg::POS_REG_LO:   held_register[7:0] <= frame_byte;
        rtu_frm_pkg::POS_QTY_HI:   held_quantity[15:8] <= frame_byte;
        rtu_frm_pkg::POS_QTY_LO:   held_quantity[7:0] <= frame_byte;
        rtu_frm_pkg::POS_CRC_LO:   held_crc_low <= frame_byte;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> design/rtu_frm_out.sv
module rtu_frm_out (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 load,
  input  rtu_frm_pkg::result_t result,
  input  logic                 out_stall,
  output logic                 out_valid,
  output rtu_frm_pkg::result_t held
);

  logic out_valid_next;

  always_comb begin
    if (load) begin
      out_valid_next = 1'b1;
    end else if (out_stall) begin
      out_valid_next = out_valid;
    end else begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= result;
    end
  end

endmodule

>>> test/rtu_request_frame_checker_unit_test.sv
module rtu_request_frame_checker_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  slave_address = rtu_frm_pkg::SLAVE_ADDRESS_RESET;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  frame_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  status;
  logic [7:0]  station;
  logic [7:0]  func_code;
  logic [15:0] register_address;
  logic [15:0] quantity;
  logic [15:0] frame_crc;

  rtu_request_frame_checker_unit dut (
    .clk              (clk),
    .rst              (rst),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .slave_address    (slave_address),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .frame_byte       (frame_byte),
    .frame_start      (frame_start),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .status           (status),
    .station          (station),
    .func_code        (func_code),
    .register_address (register_address),
    .quantity         (quantity),
    .frame_crc        (frame_crc)
  );

  // Expected frame reports, oldest first.
  rtu_frm_pkg::result_t pending_reports[$];

  // Shadow of the frame receiver.
  logic [7:0]                    own_station = rtu_frm_pkg::SLAVE_ADDRESS_RESET;
  logic [rtu_frm_pkg::CNT_W-1:0] frame_pos = rtu_frm_pkg::POS_STATION;
  logic [15:0]                   crc_acc = rtu_frm_pkg::CRC_INIT;
  logic [7:0]                    rx_station = 8'h00;
  logic [7:0]                    rx_function = 8'h00;
  logic [15:0]                   rx_register = 16'h0000;
  logic [15:0]                   rx_quantity = 16'h0000;
  logic [7:0]                    rx_crc_low = 8'h00;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int items_sent = 0;
  int mismatches = 0;
  int failures = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [15:0] crc_step(input logic [15:0] acc, input logic [7:0] data);
    logic [15:0] r;
    r = acc ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (r[0]) begin
        r = {1'b0, r[15:1]} ^ rtu_frm_pkg::CRC_POLY;
      end else begin
        r = {1'b0, r[15:1]};
      end
    end
    return r;
  endfunction

  // Advances the shadow receiver by one accepted byte.
  task automatic track_byte(input logic [7:0] b, input logic s);
    rtu_frm_pkg::result_t rep;
    logic [15:0]          got_crc;
    if (s) begin
      frame_pos = rtu_frm_pkg::POS_STATION;
      crc_acc = rtu_frm_pkg::CRC_INIT;
    end
    if (frame_pos < rtu_frm_pkg::POS_CRC_LO) crc_acc = crc_step(crc_acc, b);
    case (frame_pos)
      rtu_frm_pkg::POS_STATION:  rx_station = b;
      rtu_frm_pkg::POS_FUNCTION: rx_function = b;
      rtu_frm_pkg::POS_REG_HI:   rx_register[15:8] = b;
      rtu_frm_pkg::POS_REG_LO:   rx_register[7:0] = b;
      rtu_frm_pkg::POS_QTY_HI:   rx_quantity[15:8] = b;
      rtu_frm_pkg::POS_QTY_LO:   rx_quantity[7:0] = b;
      rtu_frm_pkg::POS_CRC_LO:   rx_crc_low = b;
      default: ;
    endcase
    if (frame_pos != rtu_frm_pkg::POS_LAST) begin
      frame_pos = frame_pos + rtu_frm_pkg::POS_STEP;
    end else begin
      got_crc = {b, rx_crc_low};
      if (got_crc != crc_acc) rep.status = rtu_frm_pkg::ST_CRC;
      else if (rx_station != own_station) rep.status = rtu_frm_pkg::ST_ADDR;
      else if (rx_function >= rtu_frm_pkg::EXCEPTION_LIMIT) rep.status = rtu_frm_pkg::ST_EXC;
      else rep.status = rtu_frm_pkg::ST_OK;
      rep.station = rx_station;
      rep.func_code = rx_function;
      rep.register_address = rx_register;
      rep.quantity = rx_quantity;
      rep.frame_crc = got_crc;
      pending_reports.push_back(rep);
      frame_pos = rtu_frm_pkg::POS_STATION;
      crc_acc = rtu_frm_pkg::CRC_INIT;
    end
  endtask

  // Called at a rising edge; returns at the edge where the item is taken.
  task automatic send_byte(input logic [7:0] b, input logic s);
    int gap;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    frame_byte <= b;
    frame_start <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    track_byte(b, s);
    items_sent++;
  endtask

  task automatic send_frame(input logic [7:0] st, input logic [7:0] fn,
                            input logic [15:0] rg, input logic [15:0] qt,
                            input logic [15:0] crc_flip, input logic lead_start);
    logic [7:0]  fb[rtu_frm_pkg::FRAME_BYTES];
    logic [15:0] crc;
    fb[0] = st;
    fb[1] = fn;
    fb[2] = rg[15:8];
    fb[3] = rg[7:0];
    fb[4] = qt[15:8];
    fb[5] = qt[7:0];
    crc = rtu_frm_pkg::CRC_INIT;
    for (int k = 0; k < rtu_frm_pkg::FRAME_BYTES - 2; k++) crc = crc_step(crc, fb[k]);
    crc = crc ^ crc_flip;
    fb[6] = crc[7:0];
    fb[7] = crc[15:8];
    for (int k = 0; k < rtu_frm_pkg::FRAME_BYTES; k++) begin
      send_byte(fb[k], (k == 0) ? lead_start : 1'b0);
    end
  endtask

  // Lets every expected report drain and the block settle before a register write.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_station(input logic [7:0] v);
    cfg_valid <= 1'b1;
    slave_address <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    own_station = v;
    cfg_valid <= 1'b0;
  endtask

  task automatic check_report();
    rtu_frm_pkg::result_t want;
    if (pending_reports.size() == 0) begin
      failures++;
      mismatches++;
      if (mismatches <= 10) $display("unexpected report: station %h function %h", station,
                                     func_code);
      return;
    end
    want = pending_reports.pop_front();
    if (status !== want.status || station !== want.station ||
        func_code !== want.func_code || register_address !== want.register_address ||
        quantity !== want.quantity || frame_crc !== want.frame_crc) begin
      failures++;
      mismatches++;
      if (mismatches <= 10) begin
        $display("report mismatch: expected st=%0d sta=%h fn=%h reg=%h qty=%h crc=%h",
                 want.status, want.station, want.func_code, want.register_address,
                 want.quantity, want.frame_crc);
        $display("                 actual   st=%0d sta=%h fn=%h reg=%h qty=%h crc=%h",
                 status, station, func_code, register_address, quantity, frame_crc);
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      check_report();
    end
    out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
  end

  // One frame for each status, under the reset station address, and the priority order
  // when several faults coincide. The last frame comes without a start flag.
  task automatic test_frame_status();
    send_frame(rtu_frm_pkg::SLAVE_ADDRESS_RESET, 8'h7F, 16'hFFFF, 16'h0000, 16'h0000, 1'b1);
    send_frame(rtu_frm_pkg::SLAVE_ADDRESS_RESET, 8'h80, 16'h0000, 16'hFFFF, 16'h0000, 1'b1);
    send_frame(8'hFF, 8'hFF, 16'h8001, 16'h7FFE, 16'h0000, 1'b1);
    send_frame(8'h00, 8'h00, 16'h0000, 16'h0000, 16'hFFFF, 1'b0);
  endtask

  // A partial frame must be dropped silently when a start flag arrives.
  task automatic test_frame_restart();
    send_byte(8'h01, 1'b1);
    send_byte(8'h03, 1'b0);
    send_byte(8'hAA, 1'b0);
    send_frame(rtu_frm_pkg::SLAVE_ADDRESS_RESET, 8'h03, 16'h1234, 16'h0010, 16'h0000, 1'b1);
  endtask

  task automatic test_random_traffic(input int target);
    int          first_item;
    int          pick;
    int          cut;
    logic        resync;
    logic [7:0]  st;
    logic [7:0]  fn;
    logic [15:0] flip;
    first_item = items_sent;
    resync = 1'b0;
    while (items_sent - first_item < target) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        st = ($urandom_range(2) != 0) ? own_station : 8'($urandom_range(255));
        fn = ($urandom_range(1) != 0) ? 8'($urandom_range(127)) : 8'($urandom_range(255));
        flip = ($urandom_range(9) == 0) ? 16'($urandom_range(1, 65535)) : 16'h0000;
        send_frame(st, fn, 16'($urandom), 16'($urandom), flip,
                   resync || ($urandom_range(3) != 0));
        resync = 1'b0;
      end else if (pick < 90) begin
        cut = $urandom_range(1, rtu_frm_pkg::FRAME_BYTES - 1);
        for (int k = 0; k < cut; k++) send_byte(8'($urandom_range(255)), k == 0);
        resync = 1'b1;
      end else begin
        send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
        resync = 1'b1;
      end
    end
  endtask

  initial begin
    int          send_pct[4] = '{0, 52, 0, 37};
    int          recv_pct[4] = '{0, 0, 52, 37};
    logic [7:0]  station_cfg[4];
    station_cfg = '{8'h00, 8'hFF, 8'($urandom_range(255)), rtu_frm_pkg::SLAVE_ADDRESS_RESET};
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_frame_status();
    test_frame_restart();
    for (int p = 0; p < 4; p++) begin
      wait_idle();
      write_station(station_cfg[p]);
      send_idle_pct = send_pct[p];
      recv_stall_pct = recv_pct[p];
      test_random_traffic(377);
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    failures += pending_reports.size();
    if (failures == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
